[rtl/b2da_pkg.sv]
// Shared constants, types and helpers for the binary to decimal ASCII converter.
package b2da_pkg;

  localparam int unsigned NumberWidth = 32;
  localparam int unsigned InWidth     = 32;
  localparam int unsigned ConvWidth   = (NumberWidth < InWidth) ? NumberWidth : InWidth;

  // Bits consumed per pipeline stage.
  localparam int unsigned StageBits = 8;
  localparam int unsigned NumStages = (ConvWidth + StageBits - 1) / StageBits;
  localparam int unsigned PadWidth  = NumStages * StageBits;

  localparam int unsigned CharWidth = 6;
  localparam logic [CharWidth-1:0] AsciiZero = CharWidth'(48);

  // Decimal digits needed for the largest ConvWidth-bit value.
  function automatic int unsigned count_digits(int unsigned width);
    longint unsigned v;
    int unsigned n;
    v = (64'd1 << width) - 64'd1;
    n = 1;
    v = v / 10;
    while (v != 0) begin
      n = n + 1;
      v = v / 10;
    end
    return n;
  endfunction

  localparam int unsigned NumDigits = count_digits(ConvWidth);
  localparam int unsigned DigitIdxW = (NumDigits > 1) ? $clog2(NumDigits) : 1;

  typedef logic [NumDigits-1:0][3:0] bcd_t;

  typedef struct packed {
    bcd_t                bcd;
    logic [PadWidth-1:0] bin;
  } dabble_t;

endpackage

[rtl/binary_to_decimal_ascii.sv]
// Binary to decimal ASCII converter, top level.
// Each request carries one unsigned number; the block returns its decimal digits
// as ASCII '0'..'9', most significant first, leading zeros dropped (zero gives a
// single '0'), with last_digit_o set on the final digit. Conversion is a
// double-dabble pipeline of NumStages stages (4 for 32 bits, 8 bits per stage).
// The serializer then sends one digit per cycle while the receiver takes them; a
// number has 1 to 10 digits, and runs follow each other without gaps while the
// pipeline keeps it fed.
module binary_to_decimal_ascii (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [b2da_pkg::InWidth-1:0]   number_value_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [b2da_pkg::CharWidth-1:0] digit_char_o,
  output logic                           last_digit_o
);
  import b2da_pkg::*;

  logic    stg_valid [NumStages+1];
  logic    stg_ready [NumStages+1];
  dabble_t stg_data  [NumStages+1];

  assign stg_valid[0]    = in_valid_i;
  assign in_ready_o      = stg_ready[0];
  assign stg_data[0].bcd = '0;
  assign stg_data[0].bin = PadWidth'(number_value_i[ConvWidth-1:0]);

  for (genvar g = 0; g < NumStages; g++) begin : g_stage
    b2da_stage u_stage (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (stg_valid[g]),
      .in_ready_o  (stg_ready[g]),
      .in_data_i   (stg_data[g]),
      .out_valid_o (stg_valid[g+1]),
      .out_ready_i (stg_ready[g+1]),
      .out_data_o  (stg_data[g+1])
    );
  end

  b2da_serial u_serial (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (stg_valid[NumStages]),
    .in_ready_o   (stg_ready[NumStages]),
    .in_bcd_i     (stg_data[NumStages].bcd),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digit_char_o (digit_char_o),
    .last_digit_o (last_digit_o)
  );

endmodule

[rtl/b2da_stage.sv]
// One double-dabble pipeline stage: StageBits shift/add-3 steps and a register.
module b2da_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  b2da_pkg::dabble_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output b2da_pkg::dabble_t out_data_o
);
  import b2da_pkg::*;

  logic    valid_q;
  dabble_t data_d, data_q;

  always_comb begin
    data_d = in_data_i;
    for (int s = 0; s < int'(StageBits); s++) begin
      for (int d = 0; d < int'(NumDigits); d++) begin
        if (data_d.bcd[d] >= 4'd5) begin
          data_d.bcd[d] = data_d.bcd[d] + 4'd3;
        end
      end
      data_d = data_d << 1;
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

[rtl/b2da_serial.sv]
// Digit serializer: skips leading zeros and sends one ASCII digit per cycle while the receiver takes them.
module b2da_serial (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  b2da_pkg::bcd_t                     in_bcd_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [b2da_pkg::CharWidth-1:0]     digit_char_o,
  output logic                               last_digit_o
);
  import b2da_pkg::*;

  bcd_t                 bcd_q;
  logic [DigitIdxW-1:0] idx_q;
  logic [DigitIdxW-1:0] lead;
  logic                 busy_q;
  logic                 out_valid_q;
  logic [3:0]           digit_q;
  logic                 last_q;
  logic                 emit;
  logic                 in_fire;
  logic                 at_end;

  // Highest nonzero digit; zero renders as a single digit.
  always_comb begin
    lead = '0;
    for (int i = 0; i < int'(NumDigits); i++) begin
      if (in_bcd_i[i] != 4'd0) begin
        lead = DigitIdxW'(i);
      end
    end
  end

  assign at_end     = (idx_q == '0);
  assign emit       = busy_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy_q || (emit && at_end);
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
        idx_q  <= lead;
      end else if (emit) begin
        busy_q <= !at_end;
        idx_q  <= idx_q - 1'b1;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      bcd_q <= in_bcd_i;
    end
    if (emit) begin
      digit_q <= bcd_q[idx_q];
      last_q  <= at_end;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = AsciiZero + {{(CharWidth-4){1'b0}}, digit_q};
  assign last_digit_o = last_q;

  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> busy_q)
    else $error("serializer not busy after load");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (idx_q < DigitIdxW'(NumDigits)))
    else $error("digit index out of range");

  a_digit_bcd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (digit_q <= 4'd9))
    else $error("non-decimal digit sent");

endmodule

[sim/binary_to_decimal_ascii_tb.sv]
// Testbench for binary_to_decimal_ascii: directed and random numbers, digit stream checked.
module binary_to_decimal_ascii_tb;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned NUM_RANDOM  = 150;

  typedef struct packed {
    logic [b2da_pkg::CharWidth-1:0] ch;
    logic                           last;
  } digit_t;

  typedef enum int {
    READY_ALWAYS,
    READY_HALF,
    READY_SPARSE,
    READY_TOGGLE
  } stall_mode_e;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_ready_o;
  logic [b2da_pkg::InWidth-1:0]   number_value_i;
  logic                           out_valid_o;
  logic                           out_ready_i;
  logic [b2da_pkg::CharWidth-1:0] digit_char_o;
  logic                           last_digit_o;

  digit_t      expected_digits[$];
  logic [31:0] row_value[$];
  string       row_text[$];
  int unsigned burst_left;
  int unsigned numbers_sent;
  int unsigned digits_checked;
  int unsigned mismatch_count;
  int unsigned cycle_count;
  logic        hold_off_armed;

  binary_to_decimal_ascii u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .number_value_i (number_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digit_char_o   (digit_char_o),
    .last_digit_o   (last_digit_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Decimal digits of the converted low bits, most significant first.
  function automatic void push_decimal_digits(input logic [31:0] value);
    logic [3:0]  digits[10];
    logic [31:0] keep;
    logic [31:0] v;
    int          count;
    digit_t      entry;
    keep  = (b2da_pkg::ConvWidth >= 32) ? '1 : (32'd1 << b2da_pkg::ConvWidth) - 32'd1;
    v     = value & keep;
    count = 0;
    do begin
      digits[count] = 4'(v % 10);
      v = v / 10;
      count++;
    end while (v != 0);
    for (int k = 0; k < count; k++) begin
      entry.ch   = b2da_pkg::AsciiZero + b2da_pkg::CharWidth'(digits[count - 1 - k]);
      entry.last = (k == count - 1);
      expected_digits.push_back(entry);
    end
  endfunction

  task automatic send_number(input logic [31:0] value, input string text);
    int unsigned gap;
    digit_t      entry;
    if (burst_left == 0) begin
      burst_left = $urandom_range(30, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i     <= 1'b1;
    number_value_i <= value;
    do @(posedge clk_i); while (!in_ready_o);
    if (text.len() == 0) begin
      push_decimal_digits(value);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        entry.ch   = b2da_pkg::CharWidth'(text[i]);
        entry.last = (i == text.len() - 1);
        expected_digits.push_back(entry);
      end
    end
    numbers_sent++;
  endtask

  // Receiver: stall pattern changes per segment, one long hold-off when armed.
  initial begin
    stall_mode_e mode;
    int unsigned seg_len;
    logic        hold_done;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      if (hold_off_armed && !hold_done) begin
        hold_done = 1'b1;
        @(posedge clk_i);
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      mode    = stall_mode_e'($urandom_range(3));
      seg_len = $urandom_range(40, 5);
      repeat (seg_len) begin
        @(posedge clk_i);
        case (mode)
          READY_ALWAYS: out_ready_i <= 1'b1;
          READY_HALF:   out_ready_i <= 1'($urandom_range(1));
          READY_SPARSE: out_ready_i <= ($urandom_range(3) == 0);
          default:      out_ready_i <= ~out_ready_i;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    digit_t exp_digit;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_digits.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected digit char=%0d last=%0b", $time, digit_char_o,
                 last_digit_o);
      end else begin
        exp_digit = expected_digits.pop_front();
        digits_checked++;
        if (digit_char_o !== exp_digit.ch) begin
          mismatch_count++;
          $display("%0t: digit_char expected %0d got %0d", $time, exp_digit.ch,
                   digit_char_o);
        end
        if (last_digit_o !== exp_digit.last) begin
          mismatch_count++;
          $display("%0t: last_digit expected %0b got %0b", $time, exp_digit.last,
                   last_digit_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d digits outstanding", cycle_count,
               expected_digits.size());
      $display("binary_to_decimal_ascii: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned      ndig;
    int unsigned      pick;
    longint unsigned  lo;
    longint unsigned  hi;
    logic [31:0]      value;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    number_value_i = '0;
    hold_off_armed = 1'b0;
    burst_left     = 0;
    numbers_sent   = 0;
    digits_checked = 0;
    mismatch_count = 0;
    cycle_count    = 0;

    row_value.push_back(32'd0);          row_text.push_back("0");
    row_value.push_back(32'd0);          row_text.push_back("0");
    row_value.push_back(32'd1);          row_text.push_back("1");
    row_value.push_back(32'd9);          row_text.push_back("9");
    row_value.push_back(32'd10);         row_text.push_back("10");
    row_value.push_back(32'd7);          row_text.push_back("7");
    row_value.push_back(32'd99);         row_text.push_back("");
    row_value.push_back(32'd100);        row_text.push_back("");
    row_value.push_back(32'd12345);      row_text.push_back("");
    row_value.push_back(32'd999999999);  row_text.push_back("");
    row_value.push_back(32'd1000000000); row_text.push_back("1000000000");
    row_value.push_back(32'hFFFFFFFF);   row_text.push_back("4294967295");
    row_value.push_back(32'hFFFFFFFE);   row_text.push_back("");
    row_value.push_back(32'h80000000);   row_text.push_back("");
    row_value.push_back(32'h7FFFFFFF);   row_text.push_back("");
    row_value.push_back(32'h55555555);   row_text.push_back("");
    row_value.push_back(32'hAAAAAAAA);   row_text.push_back("");
    row_value.push_back(32'h0000FFFF);   row_text.push_back("");
    row_value.push_back(32'hFFFF0000);   row_text.push_back("");
    row_value.push_back(32'd4000000000); row_text.push_back("");
    row_value.push_back(32'd0);          row_text.push_back("0");

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < row_value.size(); r++) send_number(row_value[r], row_text[r]);

    for (int n = 0; n < NUM_RANDOM; n++) begin
      // output side backs up once while requests keep coming
      if (n == 40) hold_off_armed <= 1'b1;
      pick = $urandom_range(9);
      ndig = $urandom_range(10, 1);
      lo   = 1;
      for (int d = 1; d < ndig; d++) lo = lo * 10;
      hi   = (ndig == 10) ? 64'hFFFFFFFF : lo * 10 - 1;
      if (pick == 0) begin
        value = $urandom;
      end else if (pick == 1) begin
        value = 32'(($urandom_range(1) == 0) ? lo : hi);
      end else begin
        value = $urandom_range(32'(hi), 32'(lo));
      end
      send_number(value, "");
    end

    in_valid_i <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("converted %0d numbers of 1 to 10 digits, %0d digit characters checked,",
             numbers_sent, digits_checked);
    $display("with bursty input and a %0d-cycle output hold-off", HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("binary_to_decimal_ascii: match");
    end else begin
      $display("binary_to_decimal_ascii: mismatch");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/b2da_pkg.sv
rtl/b2da_stage.sv
rtl/b2da_serial.sv
rtl/binary_to_decimal_ascii.sv
sim/binary_to_decimal_ascii_tb.sv
